// ===== src/cfce_pkg.sv =====
// Shared types, register codes and bit helpers for the frame check engine.
package cfce_pkg;

    // Longest frame that positions are tracked for
    localparam int MAX_FRAME_BYTES = 4096;
    localparam int POS_W = $clog2(MAX_FRAME_BYTES + 1);
    localparam int START_W = 12;
    localparam int END_W = 13;
    localparam int CMP_W = ((POS_W > END_W) ? POS_W : END_W) + 1;

    typedef enum logic [2:0] {
        MODE_CRC8  = 3'd0,
        MODE_CRC16 = 3'd1,
        MODE_CRC32 = 3'd2,
        MODE_SUM   = 3'd3,
        MODE_WORD  = 3'd4,
        MODE_BCC   = 3'd5,
        MODE_LRC   = 3'd6
    } check_mode_t;

    typedef enum logic [2:0] {
        REG_CHECK_MODE     = 3'd0,
        REG_CRC_POLYNOMIAL = 3'd1,
        REG_CRC_INITIAL    = 3'd2,
        REG_CRC_FINAL_XOR  = 3'd3,
        REG_REFLECT_INPUT  = 3'd4,
        REG_REFLECT_OUTPUT = 3'd5,
        REG_START_OFFSET   = 3'd6,
        REG_END_OFFSET     = 3'd7
    } cfg_index_t;

    localparam logic [2:0] BYTES_NONE = 3'd0;
    localparam logic [2:0] BYTES_ONE  = 3'd1;
    localparam logic [2:0] BYTES_TWO  = 3'd2;
    localparam logic [2:0] BYTES_FOUR = 3'd4;

    typedef struct packed {
        logic [2:0]         check_mode;
        logic [31:0]        crc_polynomial;
        logic [31:0]        crc_initial;
        logic [31:0]        crc_final_xor;
        logic               reflect_input;
        logic               reflect_output;
        logic [START_W-1:0] start_offset;
        logic [END_W-1:0]   end_offset;
    } cfce_cfg_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_last;
    } cfce_in_t;

    typedef struct packed {
        logic [31:0] check_value;
        logic [2:0]  check_bytes;
        logic        short_frame;
    } cfce_out_t;

    function automatic logic [7:0] rev8(input logic [7:0] x);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) begin
            r[i] = x[7-i];
        end
        return r;
    endfunction

    function automatic logic [31:0] rev32(input logic [31:0] x);
        logic [31:0] r;
        for (int i = 0; i < 32; i++) begin
            r[i] = x[31-i];
        end
        return r;
    endfunction

    function automatic logic [15:0] rot16_right(input logic [15:0] x, input logic [3:0] s);
        logic [31:0] d;
        d = {x, x} >> s;
        return d[15:0];
    endfunction

    function automatic logic [15:0] rot16_left(input logic [15:0] x, input logic [3:0] s);
        logic [31:0] d;
        d = {x, x} << s;
        return d[31:16];
    endfunction

endpackage

// ===== src/configurable_frame_check_engine.sv =====
// Frame check engine top level: input register, accumulator and result register.
//
// Accepts one frame byte per cycle and computes a CRC-8/16/32 (configurable
// polynomial, initial value, final xor and bit reflection), an 8-bit sum, a
// rotate-xor over 16-bit little-endian words, a BCC or an LRC over the bytes
// from start_offset up to end_offset. One result is delivered for the byte
// marked frame_last; short_frame flags a frame that ended before end_offset.
// A byte is taken into an input register, processed by a single pass of
// logic and, on the last byte, lands in the result register, so the
// sustained rate is one byte per cycle; the result of the last byte passes
// through the input register and then the result register. Input backs up
// only when a last byte meets a result that has not yet been taken. Write
// configuration registers only between frames, once all results have been
// delivered.
module configurable_frame_check_engine (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  cfce_pkg::cfce_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output cfce_pkg::cfce_out_t m_data,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [31:0]         cfg_wdata
);

    cfce_pkg::cfce_cfg_t cfg;
    cfce_pkg::cfce_in_t  in_reg;
    logic                in_valid_reg, in_valid_next;
    cfce_pkg::cfce_out_t out_reg;
    logic                out_valid_reg, out_valid_next;
    cfce_pkg::cfce_out_t result;
    logic                out_free;
    logic                advance;
    logic                in_xfer;

    cfce_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    cfce_accum u_accum (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .item    (in_reg),
        .advance (advance),
        .result  (result)
    );

    // Process the held byte unless its result has nowhere to go
    always_comb begin
        out_free = !out_valid_reg || m_ready;
        advance  = in_valid_reg && (!in_reg.frame_last || out_free);
        s_ready  = !in_valid_reg || advance;
        in_xfer  = s_valid && s_ready;
    end

    // Track occupancy of the input and result registers
    always_comb begin
        in_valid_next = in_xfer ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
        if (advance && in_reg.frame_last) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture payloads on transfer
    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            in_reg <= s_data;
        end
        if (advance && in_reg.frame_last) begin
            out_reg <= result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

// ===== src/cfce_cfg_regs.sv =====
// Configuration register file for the frame check engine.
module cfce_cfg_regs (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_wdata,
    output cfce_pkg::cfce_cfg_t cfg
);

    cfce_pkg::cfce_cfg_t cfg_reg;
    cfce_pkg::cfce_cfg_t cfg_next;

    // Decode the write into the addressed field
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_index)
                cfce_pkg::REG_CHECK_MODE:     cfg_next.check_mode = cfg_wdata[2:0];
                cfce_pkg::REG_CRC_POLYNOMIAL: cfg_next.crc_polynomial = cfg_wdata;
                cfce_pkg::REG_CRC_INITIAL:    cfg_next.crc_initial = cfg_wdata;
                cfce_pkg::REG_CRC_FINAL_XOR:  cfg_next.crc_final_xor = cfg_wdata;
                cfce_pkg::REG_REFLECT_INPUT:  cfg_next.reflect_input = cfg_wdata[0];
                cfce_pkg::REG_REFLECT_OUTPUT: cfg_next.reflect_output = cfg_wdata[0];
                cfce_pkg::REG_START_OFFSET:
                    cfg_next.start_offset = cfg_wdata[cfce_pkg::START_W-1:0];
                cfce_pkg::REG_END_OFFSET:
                    cfg_next.end_offset = cfg_wdata[cfce_pkg::END_W-1:0];
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== src/cfce_crc_unit.sv =====
// Byte-wide CRC update and CRC finishing for 8, 16 and 32 bit widths.
module cfce_crc_unit (
    input  logic [2:0]  check_mode,
    input  logic [31:0] crc_polynomial,
    input  logic [31:0] crc_final_xor,
    input  logic        reflect_input,
    input  logic        reflect_output,
    input  logic [31:0] rem_cur,
    input  logic [7:0]  data_byte,
    input  logic        covered,
    output logic [31:0] rem_next,
    output logic [31:0] crc_value
);

    logic [31:0] rem_al;
    logic [31:0] poly_al;
    logic [31:0] step_al;
    logic [31:0] upd_al;
    logic [31:0] mask;
    logic [31:0] out_pre;
    logic [7:0]  din;

    // Align the remainder and polynomial at the top of a 32-bit register
    always_comb begin
        case (check_mode)
            cfce_pkg::MODE_CRC8: begin
                rem_al  = {rem_cur[7:0], 24'd0};
                poly_al = {crc_polynomial[7:0], 24'd0};
                mask    = 32'h0000_00ff;
            end
            cfce_pkg::MODE_CRC16: begin
                rem_al  = {rem_cur[15:0], 16'd0};
                poly_al = {crc_polynomial[15:0], 16'd0};
                mask    = 32'h0000_ffff;
            end
            default: begin
                rem_al  = rem_cur;
                poly_al = crc_polynomial;
                mask    = 32'hffff_ffff;
            end
        endcase
    end

    // Shift eight data bits through the generator, MSB first
    always_comb begin
        din = reflect_input ? cfce_pkg::rev8(data_byte) : data_byte;
        step_al = rem_al ^ {din, 24'd0};
        for (int i = 0; i < 8; i++) begin
            step_al = step_al[31] ? ((step_al << 1) ^ poly_al) : (step_al << 1);
        end
        upd_al = covered ? step_al : rem_al;
    end

    // Return to low alignment and finish with reflection and final xor
    always_comb begin
        case (check_mode)
            cfce_pkg::MODE_CRC8:  rem_next = {24'd0, upd_al[31:24]};
            cfce_pkg::MODE_CRC16: rem_next = {16'd0, upd_al[31:16]};
            default:              rem_next = upd_al;
        endcase
        out_pre   = reflect_output ? cfce_pkg::rev32(upd_al) : rem_next;
        crc_value = (out_pre ^ crc_final_xor) & mask;
    end

endmodule

// ===== src/cfce_accum.sv =====
// Per-frame accumulator state, its byte update and the result for the last byte.
module cfce_accum (
    input  logic                aclk,
    input  logic                aresetn,
    input  cfce_pkg::cfce_cfg_t cfg,
    input  cfce_pkg::cfce_in_t  item,
    input  logic                advance,
    output cfce_pkg::cfce_out_t result
);

    localparam int POS_W = cfce_pkg::POS_W;
    localparam int CMP_W = cfce_pkg::CMP_W;
    localparam logic [CMP_W-1:0] MAX_C = CMP_W'(cfce_pkg::MAX_FRAME_BYTES);

    logic [31:0]      rem_reg, rem_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [7:0]       pend_reg, pend_next;
    logic [3:0]       wc_reg, wc_next;
    logic             first_reg, first_next;
    logic             ovf_reg, ovf_next;

    logic             frame_start;
    logic [31:0]      rem_cur;
    logic [7:0]       pend_cur;
    logic [3:0]       wc_cur;
    logic             first_cur;
    logic             ovf_cur;
    logic [CMP_W-1:0] pos_c, start_c, end_c, count_c, lim_c;
    logic             covered;
    logic             odd_byte;
    logic [8:0]       sum9;
    logic [15:0]      word;
    logic [31:0]      crc_rem_next;
    logic [31:0]      crc_value;
    logic [7:0]       sum_val;

    // Start a frame from the loaded values on its first byte
    always_comb begin
        frame_start = (pos_reg == '0);
        if (frame_start) begin
            case (cfg.check_mode)
                cfce_pkg::MODE_CRC8:  rem_cur = {24'd0, cfg.crc_initial[7:0]};
                cfce_pkg::MODE_CRC16: rem_cur = {16'd0, cfg.crc_initial[15:0]};
                cfce_pkg::MODE_CRC32: rem_cur = cfg.crc_initial;
                default:              rem_cur = '0;
            endcase
            pend_cur  = '0;
            wc_cur    = '0;
            first_cur = 1'b0;
            ovf_cur   = 1'b0;
        end else begin
            rem_cur   = rem_reg;
            pend_cur  = pend_reg;
            wc_cur    = wc_reg;
            first_cur = first_reg;
            ovf_cur   = ovf_reg;
        end
    end

    // Decide whether this position lies in the checked range
    always_comb begin
        pos_c   = CMP_W'(pos_reg);
        start_c = CMP_W'(cfg.start_offset);
        end_c   = CMP_W'(cfg.end_offset);
        count_c = pos_c + CMP_W'(1);
        covered = (pos_c < MAX_C) && (pos_c >= start_c) && (pos_c < end_c);
        lim_c   = count_c;
        if (lim_c > end_c) begin
            lim_c = end_c;
        end
        if (lim_c > MAX_C) begin
            lim_c = MAX_C;
        end
    end

    cfce_crc_unit u_crc (
        .check_mode     (cfg.check_mode),
        .crc_polynomial (cfg.crc_polynomial),
        .crc_final_xor  (cfg.crc_final_xor),
        .reflect_input  (cfg.reflect_input),
        .reflect_output (cfg.reflect_output),
        .rem_cur        (rem_cur),
        .data_byte      (item.data_byte),
        .covered        (covered),
        .rem_next       (crc_rem_next),
        .crc_value      (crc_value)
    );

    // Fold the byte into the state of the selected check
    always_comb begin
        rem_next   = rem_cur;
        pend_next  = pend_cur;
        wc_next    = wc_cur;
        first_next = first_cur;
        ovf_next   = ovf_cur;
        odd_byte   = pos_reg[0] ^ cfg.start_offset[0];
        sum9       = {1'b0, rem_cur[7:0]} + {1'b0, item.data_byte};
        word       = {item.data_byte, pend_cur};
        if (covered) begin
            case (cfg.check_mode)
                cfce_pkg::MODE_CRC8, cfce_pkg::MODE_CRC16, cfce_pkg::MODE_CRC32: begin
                    rem_next = crc_rem_next;
                end
                cfce_pkg::MODE_SUM: begin
                    rem_next = {24'd0, sum9[7:0]};
                    ovf_next = ovf_cur | sum9[8];
                end
                cfce_pkg::MODE_WORD: begin
                    if (!odd_byte) begin
                        pend_next = item.data_byte;
                    end else begin
                        if (!first_cur) begin
                            rem_next   = {16'd0, word};
                            first_next = 1'b1;
                        end else begin
                            rem_next = {16'd0,
                                        rem_cur[15:0] ^ cfce_pkg::rot16_right(word, wc_cur)};
                        end
                        wc_next = wc_cur + 4'd1;
                    end
                end
                cfce_pkg::MODE_BCC: rem_next = {24'd0, rem_cur[7:0] ^ item.data_byte};
                cfce_pkg::MODE_LRC: rem_next = {24'd0, sum9[7:0]};
                default: rem_next = rem_cur;
            endcase
        end
    end

    // Advance the position, saturating at the frame limit; clear on the last byte
    always_comb begin
        if (item.frame_last) begin
            pos_next = '0;
        end else if (pos_c < MAX_C) begin
            pos_next = pos_reg + POS_W'(1);
        end else begin
            pos_next = pos_reg;
        end
    end

    // Form the result from the updated state
    always_comb begin
        result.short_frame = (count_c < end_c);
        sum_val = 8'd0 - rem_next[7:0];
        case (cfg.check_mode)
            cfce_pkg::MODE_CRC8: begin
                result.check_value = crc_value;
                result.check_bytes = cfce_pkg::BYTES_ONE;
            end
            cfce_pkg::MODE_CRC16: begin
                result.check_value = crc_value;
                result.check_bytes = cfce_pkg::BYTES_TWO;
            end
            cfce_pkg::MODE_CRC32: begin
                result.check_value = crc_value;
                result.check_bytes = cfce_pkg::BYTES_FOUR;
            end
            cfce_pkg::MODE_SUM: begin
                result.check_value = {24'd0, ovf_next ? sum_val : rem_next[7:0]};
                result.check_bytes = cfce_pkg::BYTES_ONE;
            end
            cfce_pkg::MODE_WORD: begin
                if (first_next) begin
                    result.check_value = {16'd0, cfce_pkg::rot16_left(rem_next[15:0], wc_next)};
                end else if (lim_c == start_c + CMP_W'(1)) begin
                    result.check_value = {24'd0, pend_next};
                end else begin
                    result.check_value = '0;
                end
                result.check_bytes = cfce_pkg::BYTES_TWO;
            end
            cfce_pkg::MODE_BCC: begin
                result.check_value = {24'd0, rem_next[7:0]};
                result.check_bytes = cfce_pkg::BYTES_ONE;
            end
            cfce_pkg::MODE_LRC: begin
                result.check_value = {24'd0, sum_val};
                result.check_bytes = cfce_pkg::BYTES_ONE;
            end
            default: begin
                result.check_value = '0;
                result.check_bytes = cfce_pkg::BYTES_NONE;
            end
        endcase
    end

    // Commit the state when the held byte is processed
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg   <= '0;
            pos_reg   <= '0;
            pend_reg  <= '0;
            wc_reg    <= '0;
            first_reg <= 1'b0;
            ovf_reg   <= 1'b0;
        end else if (advance) begin
            rem_reg   <= rem_next;
            pos_reg   <= pos_next;
            pend_reg  <= pend_next;
            wc_reg    <= wc_next;
            first_reg <= first_next;
            ovf_reg   <= ovf_next;
        end
    end

endmodule
